>>> design/b64d_pkg.sv
package b64d_pkg;

   // field widths
   localparam int SymbolWidth = 8;
   localparam int LengthWidth = 21;
   localparam int SextetWidth = 6;
   localparam int AccWidth    = 12;
   localparam int PendWidth   = 3;

   // capacity register and limits
   localparam logic [LengthWidth-1:0] CAPACITY_RESET = 21'd1048576;
   localparam logic [LengthWidth-1:0] LENGTH_MAX     = 21'h1FFFFF;
   localparam logic [31:0]            MAX_OUTPUT_BYTES_DEFAULT = 32'd1048576;

   // depth of the queue between classifier and decoder
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // stream packing
   localparam int RspDataWidth = 32;

   // character classes found by the front end
   typedef enum logic [1:0] {
      CLS_BLANK,
      CLS_PAD,
      CLS_DATA,
      CLS_BAD
   } sym_class_type;

   // message status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PARSE    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // one classified character waiting in the queue
   typedef struct packed {
      sym_class_type           cls;
      logic [SextetWidth-1:0]  sextet;
      logic                    last;
   } sym_entry_type;

endpackage

>>> design/b64d_front.sv
module b64d_front
   import b64d_pkg::*;
(
   input  logic [SymbolWidth-1:0] symbol,
   input  logic                   last,
   output sym_entry_type          entry
);

   logic [SymbolWidth-1:0] upper_off;
   logic [SymbolWidth-1:0] lower_off;
   logic [SymbolWidth-1:0] digit_off;

   // offsets into the alphabet for each character range
   assign upper_off = symbol - 8'h41;
   assign lower_off = symbol - 8'h61 + 8'd26;
   assign digit_off = symbol - 8'h30 + 8'd52;

   // classify the character and look up its six-bit value
   always_comb begin
      entry.cls    = CLS_BAD;
      entry.sextet = '0;
      entry.last   = last;
      if (symbol >= 8'h41 && symbol <= 8'h5A) begin
         entry.cls    = CLS_DATA;
         entry.sextet = upper_off[SextetWidth-1:0];
      end else if (symbol >= 8'h61 && symbol <= 8'h7A) begin
         entry.cls    = CLS_DATA;
         entry.sextet = lower_off[SextetWidth-1:0];
      end else if (symbol >= 8'h30 && symbol <= 8'h39) begin
         entry.cls    = CLS_DATA;
         entry.sextet = digit_off[SextetWidth-1:0];
      end else if (symbol == 8'h2B) begin
         entry.cls    = CLS_DATA;
         entry.sextet = 6'd62;
      end else if (symbol == 8'h2F) begin
         entry.cls    = CLS_DATA;
         entry.sextet = 6'd63;
      end else if (symbol == 8'h3D) begin
         entry.cls = CLS_PAD;
      end else if (symbol == 8'h20 || symbol == 8'h09 || symbol == 8'h0D
                   || symbol == 8'h0A) begin
         entry.cls = CLS_BLANK;
      end
   end

endmodule

>>> design/b64d_queue.sv
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  sym_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output sym_entry_type pop_entry
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);

   sym_entry_type         store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != CountFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/b64d_back.sv
module b64d_back
   import b64d_pkg::*;
#(
   parameter logic [31:0] MAX_OUTPUT_BYTES = MAX_OUTPUT_BYTES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [LengthWidth-1:0] csr_wdata,
   input  logic                   entry_valid,
   output logic                   entry_ready,
   input  sym_entry_type          entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_byte_valid,
   output logic                   out_done,
   output status_type             out_status,
   output logic [LengthWidth-1:0] out_length
);

   localparam logic [LengthWidth-1:0] MaxLimit =
      (MAX_OUTPUT_BYTES > 32'(LENGTH_MAX)) ? LENGTH_MAX : MAX_OUTPUT_BYTES[LengthWidth-1:0];

   logic [LengthWidth-1:0] capacity_ff;
   logic [LengthWidth-1:0] limit;

   logic [AccWidth-1:0]    acc_ff, acc_in, acc_next;
   logic [PendWidth-1:0]   pend_ff, pend_in, pend_next;
   logic                   pad_ff, pad_in;
   status_type             err_ff, err_in, err_upd;
   logic [LengthWidth-1:0] count_ff, count_in, count_upd;

   logic                   advance;
   logic                   take;
   logic                   have_byte;
   logic [7:0]             byte_val;
   logic                   produce;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff;
   logic                   out_byte_valid_ff;
   logic                   out_done_ff;
   status_type             out_status_ff;
   logic [LengthWidth-1:0] out_length_ff;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wen) begin
         capacity_ff <= csr_wdata;
      end
   end

   assign limit = (capacity_ff < MaxLimit) ? capacity_ff : MaxLimit;

   // take a word whenever the output register is free or being drained
   assign advance     = !out_valid_ff || out_ready;
   assign entry_ready = advance;
   assign take        = entry_valid && advance;

   assign acc_next  = {acc_ff[AccWidth-SextetWidth-1:0], entry.sextet};
   assign pend_next = pend_ff - 3'd2;

   // byte extraction from the shifted accumulator
   always_comb begin
      case (pend_next)
         3'd0:    byte_val = acc_next[7:0];
         3'd2:    byte_val = acc_next[9:2];
         default: byte_val = acc_next[11:4];
      endcase
   end

   // decoder state update
   always_comb begin
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      pad_in    = pad_ff;
      err_upd   = err_ff;
      count_upd = count_ff;
      have_byte = 1'b0;
      if (take && err_ff == STATUS_OK) begin
         if (pad_ff) begin
            if (entry.cls != CLS_PAD && entry.cls != CLS_BLANK) begin
               err_upd = STATUS_PARSE;
            end
         end else begin
            unique case (entry.cls)
               CLS_BLANK: ;
               CLS_PAD:   pad_in = 1'b1;
               CLS_BAD:   err_upd = STATUS_PARSE;
               CLS_DATA: begin
                  acc_in = acc_next;
                  if (pend_ff >= 3'd2) begin
                     pend_in = pend_next;
                     if (count_ff >= limit) begin
                        err_upd = STATUS_OVERFLOW;
                     end else begin
                        count_upd = count_ff + 1'b1;
                        have_byte = 1'b1;
                     end
                  end else begin
                     pend_in = pend_ff + 3'd6;
                  end
               end
            endcase
         end
      end
      err_in   = err_upd;
      count_in = count_upd;
      // last character closes the message
      if (take && entry.last) begin
         acc_in   = '0;
         pend_in  = '0;
         pad_in   = 1'b0;
         err_in   = STATUS_OK;
         count_in = '0;
      end
      produce      = have_byte || entry.last;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = take && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pend_ff      <= '0;
         pad_ff       <= 1'b0;
         err_ff       <= STATUS_OK;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         pad_ff       <= pad_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (take && produce) begin
         out_byte_ff       <= have_byte ? byte_val : 8'd0;
         out_byte_valid_ff <= have_byte;
         out_done_ff       <= entry.last;
         out_status_ff     <= entry.last ? err_upd : STATUS_OK;
         out_length_ff     <= (entry.last && err_upd == STATUS_OK) ? count_upd : '0;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_byte       = out_byte_ff;
   assign out_byte_valid = out_byte_valid_ff;
   assign out_done       = out_done_ff;
   assign out_status     = out_status_ff;
   assign out_length     = out_length_ff;

endmodule

>>> design/base64_stream_decoder.sv
// Base64 decoder taking one character word per clock. Each accepted word is
// classified (alphabet, pad, whitespace or invalid) and queued in a small
// QUEUE_DEPTH-entry queue; the decoder behind it takes one queued word per
// cycle, so the sustained rate is one character per clock while rsp_tready
// stays high. A result word passes through the queue storage and then the
// output register before it appears on the rsp side.
// A result is sent for every decoded byte and for the character marked
// req_tlast, which also carries the message status and length (length is 0
// on error). After a parse or overflow error nothing is sent until the last
// character. csr_wdata sets the per-message byte capacity (reset 1048576);
// the limit used is the smaller of it and MAX_OUTPUT_BYTES, and it should be
// written only while no message is in flight.
module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter logic [31:0] MAX_OUTPUT_BYTES = MAX_OUTPUT_BYTES_DEFAULT,
   parameter int          QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   // input characters
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SymbolWidth-1:0]  req_tdata,   // [7:0] symbol
   input  logic                    req_tlast,   // end_of_message
   // decoded results
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // [7:0] data_byte, [9:8] status,
                                                // [30:10] decoded_length, [31] zero
   output logic                    rsp_tuser,   // byte_valid
   output logic                    rsp_tlast,   // message_done
   // capacity register
   input  logic                    csr_wen,
   input  logic [LengthWidth-1:0]  csr_wdata
);

   sym_entry_type          front_entry;
   sym_entry_type          queue_entry;
   logic                   queue_valid;
   logic                   queue_ready;
   logic [7:0]             out_byte;
   status_type             out_status;
   logic [LengthWidth-1:0] out_length;

   // character classification
   b64d_front u_front (
      .symbol (req_tdata),
      .last   (req_tlast),
      .entry  (front_entry)
   );

   // queue between classifier and decoder
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_entry  (queue_entry)
   );

   // bit accumulation, limits and status
   b64d_back #(
      .MAX_OUTPUT_BYTES (MAX_OUTPUT_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .entry_valid    (queue_valid),
      .entry_ready    (queue_ready),
      .entry          (queue_entry),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (out_byte),
      .out_byte_valid (rsp_tuser),
      .out_done       (rsp_tlast),
      .out_status     (out_status),
      .out_length     (out_length)
   );

   // result word packing
   assign rsp_tdata = {1'b0, out_length, out_status, out_byte};

   // a word without a byte must close a message
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("result word with neither byte nor message end");

   // status and length only on the closing word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[30:8] == '0)
      else $error("status or length on a word that is not the last");

   // an error report carries no length and no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:8] != 2'd0 |-> rsp_tdata[30:10] == '0 && !rsp_tuser)
      else $error("error report with non-zero length or a byte");

endmodule

>>> dv/b64d_decode_checker.sv
module b64d_decode_checker
   import b64d_pkg::*;
#(
   parameter logic [31:0] MAX_OUTPUT_BYTES = MAX_OUTPUT_BYTES_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [SymbolWidth-1:0]  req_tdata,
   input  logic                    req_tlast,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    rsp_tuser,
   input  logic                    rsp_tlast,
   input  logic                    csr_wen,
   input  logic [LengthWidth-1:0]  csr_wdata,
   output int                      mismatches,
   output int                      words_due
);

   // one decoded result word as the block should send it
   typedef struct packed {
      logic [7:0]             data_byte;
      logic                   byte_valid;
      logic                   message_done;
      status_type             status;
      logic [LengthWidth-1:0] decoded_length;
   } decoded_word_type;

   decoded_word_type decoded_words_due[$];

   // mirror of the decoder state
   logic [LengthWidth-1:0] byte_capacity;
   logic [AccWidth-1:0]    bit_store;
   int                     bits_held;
   logic                   pad_found;
   status_type             message_fault;
   logic [LengthWidth-1:0] bytes_so_far;

   initial mismatches = 0;
   initial words_due = 0;

   function automatic int sextet_value(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return ch - "A";
      if (ch >= "a" && ch <= "z") return ch - "a" + 26;
      if (ch >= "0" && ch <= "9") return ch - "0" + 52;
      if (ch == "+") return 62;
      if (ch == "/") return 63;
      return 64;
   endfunction

   function automatic logic is_space_char(input logic [7:0] ch);
      return ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A;
   endfunction

   task automatic clear_message();
      bit_store = '0;
      bits_held = 0;
      pad_found = 1'b0;
      message_fault = STATUS_OK;
      bytes_so_far = '0;
   endtask

   // decode one character word and queue the result it causes, if any
   task automatic decode_symbol(input logic [7:0] ch, input logic last);
      decoded_word_type w;
      logic             have_byte;
      logic [7:0]       out_byte;
      int               sx;
      logic [31:0]      byte_limit;
      have_byte = 1'b0;
      out_byte = 8'h00;
      byte_limit = {11'd0, byte_capacity};
      if (MAX_OUTPUT_BYTES < byte_limit) byte_limit = MAX_OUTPUT_BYTES;
      if (message_fault == STATUS_OK) begin
         if (pad_found) begin
            if (!(ch == "=" || is_space_char(ch))) message_fault = STATUS_PARSE;
         end else if (ch == "=") begin
            pad_found = 1'b1;
         end else if (!is_space_char(ch)) begin
            sx = sextet_value(ch);
            if (sx > 63) begin
               message_fault = STATUS_PARSE;
            end else begin
               bit_store = {bit_store[AccWidth-7:0], sx[5:0]};
               bits_held += 6;
               if (bits_held >= 8) begin
                  bits_held -= 8;
                  out_byte = 8'(bit_store >> bits_held);
                  if ({11'd0, bytes_so_far} + 32'd1 > byte_limit) begin
                     message_fault = STATUS_OVERFLOW;
                  end else begin
                     bytes_so_far += 1'b1;
                     have_byte = 1'b1;
                  end
               end
            end
         end
      end
      if (have_byte || last) begin
         w.data_byte = have_byte ? out_byte : 8'h00;
         w.byte_valid = have_byte;
         w.message_done = last;
         w.status = last ? message_fault : STATUS_OK;
         w.decoded_length = (last && message_fault == STATUS_OK) ? bytes_so_far : '0;
         decoded_words_due.push_back(w);
      end
      if (last) clear_message();
   endtask

   // compare one received result word with the oldest prediction
   task automatic check_word();
      decoded_word_type w;
      if (decoded_words_due.size() == 0) begin
         $error("result word with nothing expected: tdata %0h", rsp_tdata);
         mismatches++;
         return;
      end
      w = decoded_words_due.pop_front();
      if (rsp_tdata[7:0] !== w.data_byte) begin
         $error("data_byte: expected %0h, actual %0h", w.data_byte, rsp_tdata[7:0]);
         mismatches++;
      end
      if (rsp_tuser !== w.byte_valid) begin
         $error("byte_valid: expected %0h, actual %0h", w.byte_valid, rsp_tuser);
         mismatches++;
      end
      if (rsp_tlast !== w.message_done) begin
         $error("message_done: expected %0h, actual %0h", w.message_done, rsp_tlast);
         mismatches++;
      end
      if (rsp_tdata[9:8] !== w.status) begin
         $error("status: expected %0h, actual %0h", w.status, rsp_tdata[9:8]);
         mismatches++;
      end
      if (rsp_tdata[30:10] !== w.decoded_length) begin
         $error("decoded_length: expected %0h, actual %0h",
                w.decoded_length, rsp_tdata[30:10]);
         mismatches++;
      end
   endtask

   // watch the three ports at every edge
   always @(posedge clock) begin
      if (reset) begin
         byte_capacity = CAPACITY_RESET;
         clear_message();
         decoded_words_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_word();
         if (csr_wen) byte_capacity = csr_wdata;
         if (req_tvalid && req_tready) decode_symbol(req_tdata, req_tlast);
      end
      words_due = decoded_words_due.size();
   end

endmodule

>>> dv/tb.sv
module tb;
   import b64d_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_WORDS   = 153;

   // one character word to send
   typedef struct packed {
      logic       last;
      logic [7:0] symbol;
   } char_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SymbolWidth-1:0]  req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_wen = 1'b0;
   logic [LengthWidth-1:0]  csr_wdata = '0;

   int                      mismatches;
   int                      words_due;
   bit                      calm = 1'b0;
   int                      stall_left = 0;
   int                      words_sent = 0;
   char_word_type           text[$];
   logic [LengthWidth-1:0]  cap_plan[7];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   base64_stream_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   b64d_decode_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic logic [7:0] alpha_char(input logic [5:0] v);
      if (v < 26) return "A" + v;
      if (v < 52) return "a" + (v - 26);
      if (v < 62) return "0" + (v - 52);
      return (v == 62) ? "+" : "/";
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(0, 3))
         0: return " ";
         1: return 8'h09;
         2: return 8'h0D;
         default: return 8'h0A;
      endcase
   endfunction

   task automatic put_word(input logic [7:0] sym, input logic last);
      char_word_type w;
      w.symbol = sym;
      w.last = last;
      text.push_back(w);
   endtask

   // character with an occasional whitespace character ahead of it
   task automatic add_char(input logic [7:0] sym);
      if ($urandom_range(0, 7) == 0) put_word(space_char(), 1'b0);
      put_word(sym, 1'b0);
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
      text[$].last = 1'b1;
   endtask

   // well-formed encoding of random bytes, sometimes spoilt
   task automatic build_message(input int nbytes, input bit spoil);
      logic [7:0]  raw[$];
      logic [23:0] grp;
      int          n;
      int          pos;
      for (int i = 0; i < nbytes; i++) raw.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < nbytes; i += 3) begin
         n = (nbytes - i >= 3) ? 3 : nbytes - i;
         grp = {raw[i], (n > 1) ? raw[i+1] : 8'h00, (n > 2) ? raw[i+2] : 8'h00};
         for (int k = 0; k <= n; k++) add_char(alpha_char(grp[23-6*k -: 6]));
         if (n < 3 && $urandom_range(0, 3) != 0) begin
            for (int k = n; k < 3; k++) add_char("=");
         end
      end
      if (spoil) begin
         pos = (text.size() == 0) ? 0 : $urandom_range(0, text.size() - 1);
         case ($urandom_range(0, 4))
            0: begin
               text.insert(pos, char_word_type'({1'b0, 8'($urandom_range(0, 255))}));
            end
            1: begin
               add_char("=");
               add_char(alpha_char(6'($urandom_range(0, 63))));
            end
            2: begin
               if (text.size() > 0) text[pos].symbol = 8'($urandom_range(0, 255));
            end
            3: begin
               while (text.size() > pos + 1) void'(text.pop_back());
            end
            default: begin
               text.delete();
               repeat ($urandom_range(1, 6)) put_word(8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
      end
      if (text.size() == 0) put_word(($urandom_range(0, 1) != 0) ? "=" : space_char(), 1'b0);
      text[$].last = 1'b1;
   endtask

   task automatic send_word(input char_word_type w, input bit gappy);
      if (gappy && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w.symbol;
      req_tlast <= w.last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text();
      bit gappy;
      gappy = !calm && $urandom_range(0, 3) != 0;
      foreach (text[i]) send_word(text[i], gappy);
      words_sent += text.size();
      text.delete();
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (words_due == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [LengthWidth-1:0] v);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int phase_start;
      cap_plan = '{21'd1, 21'd0, 21'd5, LENGTH_MAX, 21'd0, 21'd2, CAPACITY_RESET};
      cap_plan[4] = 21'($urandom_range(0, 2097151));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed messages at the reset capacity
      load_text("TWFu");
      send_text();
      load_text(" AZaz\t09+/=\015\n");
      send_text();
      put_word(8'h00, 1'b0);
      put_word(8'hFF, 1'b0);
      put_word("=", 1'b1);
      send_text();
      put_word(8'hFF, 1'b1);
      send_text();
      load_text("=Q");
      send_text();

      // random messages under a run of capacities
      foreach (cap_plan[p]) begin
         settle();
         write_capacity(cap_plan[p]);
         if (p == 0) begin
            // capacity of one byte overflows on the second
            load_text("QUJD");
            send_text();
         end
         if (p == $size(cap_plan) - 1) calm = 1'b1;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            build_message(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(0, 12),
                          $urandom_range(0, 4) == 0);
            send_text();
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
